FILE: rtl/rrpg_pkg.sv
// Shared constants and codes for the rainbow ring pixel generator.
// No dependencies; imported by the top level.
package rrpg_pkg;

	// action codes of an input item
	localparam logic [1:0] ACT_RESTART = 2'd0;
	localparam logic [1:0] ACT_ADVANCE = 2'd1;
	localparam logic [1:0] ACT_PIXEL   = 2'd2;

	// face grid and hue offsets in Q0.16 turns
	localparam int unsigned GRID_SIZE     = 8;
	localparam int unsigned RING_HUE_STEP = 5243;
	localparam int unsigned FACE_HUE_STEP = 2621;

	// speed register: reset value and advance offset (0.1 turn/s scaled)
	localparam logic [7:0] SPEED_RESET  = 8'd128;
	localparam logic [9:0] SPEED_OFFSET = 10'd51;

	// configuration port
	localparam int unsigned PADDR_W   = 3;
	localparam logic        REG_SPEED = 1'b0;

endpackage

FILE: rtl/rainbow_ring_pixel_generator.sv
// Rainbow ring pixel generator: hue phase accumulator and hue-wheel coloring.
// Depends on rrpg_pkg for action codes, grid size and hue constants.
//
// The block takes one item per clock and keeps that rate with no stall of its
// own: an item flows through an input register, a multiply stage for the phase
// step, a hue stage where the phase is read and updated, and a color stage
// into the output register. Restart and advance items give no result; a later
// pixel item always sees the phase that the earlier items left, since the phase
// is read and written in the same stage in item order. Only a stalled output
// with the internal stages full holds back new items. The speed register at
// byte address 0 may be written only while no item is in flight.
module rainbow_ring_pixel_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	// item input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic [15:0]                  time_step,
	input  logic [2:0]                   face_index,
	input  logic [2:0]                   column,
	input  logic [2:0]                   row,
	// result output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   red,
	output logic [7:0]                   green,
	output logic [7:0]                   blue,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rrpg_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import rrpg_pkg::*;

	localparam logic [2:0] LAST = 3'(GRID_SIZE - 1);

	// configuration and phase state
	logic [7:0]  speed_q;
	logic [15:0] phase_q;

	// stage 1: input register
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [15:0] time_step_s1;
	logic [2:0]  face_s1;
	logic [2:0]  column_s1;
	logic [2:0]  row_s1;

	// stage 2: product and ring
	logic        valid_s2;
	logic [1:0]  action_s2;
	logic [25:0] prod_s2;
	logic [2:0]  face_s2;
	logic [2:0]  ring_s2;

	// stage 3: hue of a pixel
	logic        valid_s3;
	logic [15:0] hue_s3;

	// output register
	logic        out_valid_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;

	// flow control, back to front
	logic out_free, s3_free, s2_fire, s2_free, s1_fire, s1_free, in_fire;
	logic s2_is_pixel;

	assign s2_is_pixel = (action_s2 == ACT_PIXEL);
	assign out_free    = !out_valid_q || !out_stall;
	assign s3_free     = !valid_s3 || out_free;
	assign s2_fire     = valid_s2 && (!s2_is_pixel || s3_free);
	assign s2_free     = !valid_s2 || s2_fire;
	assign s1_fire     = valid_s1 && s2_free;
	assign s1_free     = !valid_s1 || s1_fire;
	assign in_fire     = in_valid && s1_free;
	assign in_stall    = !s1_free;

	// configuration port
	logic cfg_write;
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_SPEED) ? {24'd0, speed_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
		end else if (cfg_write && paddr[2] == REG_SPEED) begin
			speed_q <= pwdata[7:0];
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1    <= action;
			time_step_s1 <= time_step;
			face_s1      <= face_index;
			column_s1    <= column;
			row_s1       <= row;
		end
	end

	// stage 1 logic: step product and ring distance
	logic [9:0]  mult_s1;
	logic [25:0] prod_s1;
	logic [2:0]  col_c, row_c, ring_x, ring_y, ring_s1;

	assign mult_s1 = {1'b0, speed_q, 1'b0} + SPEED_OFFSET;
	assign prod_s1 = time_step_s1 * mult_s1;

	always_comb begin
		col_c   = (column_s1 > LAST) ? LAST : column_s1;
		row_c   = (row_s1 > LAST) ? LAST : row_s1;
		ring_x  = (col_c < LAST - col_c) ? col_c : LAST - col_c;
		ring_y  = (row_c < LAST - row_c) ? row_c : LAST - row_c;
		ring_s1 = (ring_x < ring_y) ? ring_x : ring_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			action_s2 <= action_s1;
			prod_s2   <= prod_s1;
			face_s2   <= face_s1;
			ring_s2   <= ring_s1;
		end
	end

	// stage 2 logic: step = floor(prod/1020) = floor((prod>>2)/255),
	// with x/255 = ((x+1)*65793) >> 24 exact below 2^24
	logic [24:0] quot_in;
	logic [40:0] quot_sum;
	logic [15:0] inc_s2;
	logic [15:0] hue_s2;

	assign quot_in  = {1'b0, prod_s2[25:2]} + 25'd1;
	assign quot_sum = {quot_in, 16'd0} + {8'd0, quot_in, 8'd0} + {16'd0, quot_in};
	assign inc_s2   = quot_sum[39:24];
	assign hue_s2   = phase_q + 16'(ring_s2 * RING_HUE_STEP)
	                          + 16'(face_s2 * FACE_HUE_STEP);

	// phase update in item order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 16'd0;
		end else if (s2_fire) begin
			case (action_s2)
				ACT_RESTART: phase_q <= 16'd0;
				ACT_ADVANCE: phase_q <= phase_q + inc_s2;
				default:     phase_q <= phase_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= s2_fire && s2_is_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && s2_fire && s2_is_pixel) begin
			hue_s3 <= hue_s2;
		end
	end

	// stage 3 logic: six-segment hue wheel
	logic [18:0] h6;
	logic [2:0]  seg;
	logic [16:0] ramp;
	logic [24:0] ramp_255;
	logic [7:0]  level;
	logic [7:0]  red_d, green_d, blue_d;

	assign h6       = {1'b0, hue_s3, 2'b0} + {2'b0, hue_s3, 1'b0};
	assign seg      = h6[18:16];
	assign ramp     = seg[0] ? (17'h10000 - {1'b0, h6[15:0]}) : {1'b0, h6[15:0]};
	assign ramp_255 = {ramp, 8'd0} - {8'd0, ramp};
	assign level    = ramp_255[23:16];

	always_comb begin
		case (seg)
			3'd0:    begin red_d = 8'd255; green_d = level;  blue_d = 8'd0;   end
			3'd1:    begin red_d = level;  green_d = 8'd255; blue_d = 8'd0;   end
			3'd2:    begin red_d = 8'd0;   green_d = 8'd255; blue_d = level;  end
			3'd3:    begin red_d = 8'd0;   green_d = level;  blue_d = 8'd255; end
			3'd4:    begin red_d = level;  green_d = 8'd0;   blue_d = 8'd255; end
			default: begin red_d = 8'd255; green_d = 8'd0;   blue_d = level;  end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

	// a restart leaves the phase at zero
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s2_fire && action_s2 == ACT_RESTART |=> phase_q == 16'd0)
		else $error("phase not cleared after restart");

	// a pixel waiting in stage 3 keeps its hue
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_free |=> valid_s3 && $stable(hue_s3))
		else $error("stage 3 pixel lost while output stalled");

	// input is stalled only when stages 1 and 2 both hold an item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with free pipeline");

endmodule

FILE: tb/rainbow_ring_pixel_generator_tb.sv
// Self-checking testbench for the rainbow ring pixel generator: hue phase
// tracking, ring/face hue offsets and hue-wheel colors, under random stalls.
// Depends on rrpg_pkg and the rainbow_ring_pixel_generator top level.
`timescale 1ns / 1ps

module rainbow_ring_pixel_generator_tb;
	import rrpg_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int unsigned ADVANCE_DIVISOR = 1020;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 60;
	localparam int PHASE_ITEMS = 200;
	localparam logic [PADDR_W-1:0] SPEED_ADDR = PADDR_W'(4 * REG_SPEED);

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] time_step;
		logic [2:0]  face;
		logic [2:0]  col;
		logic [2:0]  row;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		item_t it;
		logic  typed;
		rgb_t  want;
	} dir_row_t;

	typedef enum int unsigned {
		SEG_RED_TO_YELLOW,
		SEG_YELLOW_TO_GREEN,
		SEG_GREEN_TO_CYAN,
		SEG_CYAN_TO_BLUE,
		SEG_BLUE_TO_MAGENTA,
		SEG_MAGENTA_TO_RED
	} hue_seg_t;

	localparam rgb_t PURE_RED = '{8'd255, 8'd0, 8'd0};
	localparam rgb_t NO_RGB   = '{8'd0, 8'd0, 8'd0};

	// directed items: extremes, every action, ignored code, phase wrap
	localparam int N_DIRECTED = 24;
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{'{ACT_PIXEL,   16'd0,     3'd0, 3'd0, 3'd0}, 1'b1, PURE_RED},
		'{'{ACT_PIXEL,   16'd0,     3'd0, 3'd7, 3'd7}, 1'b1, PURE_RED},
		'{'{ACT_PIXEL,   16'd0,     3'd0, 3'd0, 3'd7}, 1'b1, PURE_RED},
		'{'{ACT_PIXEL,   16'd0,     3'd0, 3'd7, 3'd0}, 1'b1, PURE_RED},
		'{'{ACT_PIXEL,   16'd0,     3'd7, 3'd7, 3'd7}, 1'b0, NO_RGB},
		'{'{ACT_PIXEL,   16'd0,     3'd5, 3'd3, 3'd4}, 1'b0, NO_RGB},
		'{'{ACT_PIXEL,   16'd0,     3'd0, 3'd4, 3'd3}, 1'b0, NO_RGB},
		'{'{ACT_PIXEL,   16'd0,     3'd6, 3'd2, 3'd5}, 1'b0, NO_RGB},
		'{'{ACT_UNUSED,  16'hFFFF,  3'd7, 3'd7, 3'd7}, 1'b0, NO_RGB},
		'{'{ACT_PIXEL,   16'd0,     3'd0, 3'd0, 3'd0}, 1'b1, PURE_RED},
		'{'{ACT_ADVANCE, 16'd0,     3'd0, 3'd0, 3'd0}, 1'b0, NO_RGB},
		'{'{ACT_PIXEL,   16'd0,     3'd0, 3'd0, 3'd0}, 1'b1, PURE_RED},
		'{'{ACT_ADVANCE, 16'hFFFF,  3'd0, 3'd0, 3'd0}, 1'b0, NO_RGB},
		'{'{ACT_ADVANCE, 16'hFFFF,  3'd0, 3'd0, 3'd0}, 1'b0, NO_RGB},
		'{'{ACT_ADVANCE, 16'hFFFF,  3'd0, 3'd0, 3'd0}, 1'b0, NO_RGB},
		'{'{ACT_ADVANCE, 16'hFFFF,  3'd0, 3'd0, 3'd0}, 1'b0, NO_RGB},
		'{'{ACT_PIXEL,   16'd0,     3'd1, 3'd1, 3'd6}, 1'b0, NO_RGB},
		'{'{ACT_PIXEL,   16'd0,     3'd2, 3'd2, 3'd2}, 1'b0, NO_RGB},
		'{'{ACT_RESTART, 16'hFFFF,  3'd7, 3'd7, 3'd7}, 1'b0, NO_RGB},
		'{'{ACT_PIXEL,   16'd0,     3'd0, 3'd0, 3'd0}, 1'b1, PURE_RED},
		'{'{ACT_ADVANCE, 16'd1,     3'd0, 3'd0, 3'd0}, 1'b0, NO_RGB},
		'{'{ACT_ADVANCE, 16'd4,     3'd0, 3'd0, 3'd0}, 1'b0, NO_RGB},
		'{'{ACT_PIXEL,   16'd0,     3'd3, 3'd5, 3'd1}, 1'b0, NO_RGB},
		'{'{ACT_PIXEL,   16'd0,     3'd4, 3'd6, 3'd0}, 1'b0, NO_RGB}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [15:0] time_step;
	logic [2:0]  face_index;
	logic [2:0]  column;
	logic [2:0]  row;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// predictor state and expected colors
	logic [15:0] model_phase;
	logic [7:0]  model_speed;
	rgb_t        pending_colors[$];

	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	rainbow_ring_pixel_generator u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.time_step  (time_step),
		.face_index (face_index),
		.column     (column),
		.row        (row),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("rainbow_ring_pixel_generator_tb NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// six-segment hue wheel at full saturation and value
	function automatic rgb_t hue_to_rgb(input logic [15:0] hue);
		int unsigned h6;
		int unsigned frac;
		int unsigned lvl;
		hue_seg_t seg;
		rgb_t c;
		h6 = 32'(hue) * 6;
		seg = hue_seg_t'(h6 >> 16);
		frac = h6 & 32'hFFFF;
		if (h6[16])
			lvl = ((32'd65536 - frac) * 255) >> 16;
		else
			lvl = (frac * 255) >> 16;
		case (seg)
			SEG_RED_TO_YELLOW:   c = '{8'd255, 8'(lvl), 8'd0};
			SEG_YELLOW_TO_GREEN: c = '{8'(lvl), 8'd255, 8'd0};
			SEG_GREEN_TO_CYAN:   c = '{8'd0, 8'd255, 8'(lvl)};
			SEG_CYAN_TO_BLUE:    c = '{8'd0, 8'(lvl), 8'd255};
			SEG_BLUE_TO_MAGENTA: c = '{8'(lvl), 8'd0, 8'd255};
			default:             c = '{8'd255, 8'd0, 8'(lvl)};
		endcase
		return c;
	endfunction

	// update phase for one accepted item, return its color if any
	task automatic apply_item(input item_t it, output bit has_color, output rgb_t color);
		int unsigned last;
		int unsigned c;
		int unsigned r;
		int unsigned ring;
		int unsigned step_inc;
		last = GRID_SIZE - 1;
		has_color = 1'b0;
		color = NO_RGB;
		case (it.action)
			ACT_RESTART: model_phase = '0;
			ACT_ADVANCE: begin
				step_inc = (32'(it.time_step) * (2 * 32'(model_speed) + 32'(SPEED_OFFSET)))
					/ ADVANCE_DIVISOR;
				model_phase = 16'(32'(model_phase) + step_inc);
			end
			ACT_PIXEL: begin
				c = (32'(it.col) > last) ? last : 32'(it.col);
				r = (32'(it.row) > last) ? last : 32'(it.row);
				ring = c;
				if (last - c < ring) ring = last - c;
				if (r < ring) ring = r;
				if (last - r < ring) ring = last - r;
				color = hue_to_rgb(16'(32'(model_phase) + ring * RING_HUE_STEP
					+ 32'(it.face) * FACE_HUE_STEP));
				has_color = 1'b1;
			end
			default: ;
		endcase
	endtask

	function automatic item_t random_item();
		item_t it;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8)
			it.action = ACT_RESTART;
		else if (pick < 38)
			it.action = ACT_ADVANCE;
		else if (pick < 95)
			it.action = ACT_PIXEL;
		else
			it.action = ACT_UNUSED;
		if ($urandom_range(1) == 0)
			it.time_step = 16'($urandom);
		else
			it.time_step = 16'($urandom_range(255));
		it.face = 3'($urandom_range(7));
		it.col = 3'($urandom_range(7));
		it.row = 3'($urandom_range(7));
		return it;
	endfunction

	// offer one item, with random idle cycles first, until accepted
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.action;
		time_step <= it.time_step;
		face_index <= it.face;
		column <= it.col;
		row <= it.row;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_and_track(input item_t it, input logic typed, input rgb_t want);
		bit has_color;
		rgb_t color;
		send_item(it);
		apply_item(it, has_color, color);
		if (has_color)
			pending_colors.push_back(typed ? want : color);
	endtask

	// stop offering until every expected color is back, then let the pipe empty
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write the speed register, then read it back in the next transfer
	task automatic program_speed(input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SPEED_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		model_speed = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(model_speed))
			report_mismatch("speed readback", int'(prdata), int'(model_speed));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// receiver: random stalls plus requested long hold-offs
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// compare each accepted color with the oldest expectation
	always @(posedge clk) begin : check_colors
		rgb_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_colors.size() == 0)
				report_mismatch("color with none queued", int'({red, green, blue}), -1);
			else begin
				want = pending_colors.pop_front();
				if (red !== want.red)
					report_mismatch("red", int'(red), int'(want.red));
				if (green !== want.green)
					report_mismatch("green", int'(green), int'(want.green));
				if (blue !== want.blue)
					report_mismatch("blue", int'(blue), int'(want.blue));
			end
		end
	end

	// stimulus
	initial begin : stimulus
		logic [7:0] phase_speed;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_RESTART;
		time_step <= '0;
		face_index <= '0;
		column <= '0;
		row <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		model_phase = '0;
		model_speed = SPEED_RESET;
		send_idle_pct = 20;
		recv_idle_pct = 70;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset speed
		for (int i = 0; i < N_DIRECTED; i++)
			send_and_track(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].want);
		drain_results();

		// random phases: slowest, fastest, then a random speed
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: phase_speed = 8'd0;
				1: phase_speed = 8'd255;
				default: phase_speed = 8'($urandom_range(1, 254));
			endcase
			send_idle_pct = (p == 0) ? 20 : (p == 1) ? 70 : 0;
			recv_idle_pct = (p == 0) ? 70 : (p == 1) ? 20 : 0;
			program_speed(phase_speed);
			// long output hold-off while items keep coming
			if (p == 2)
				hold_request = LONG_HOLD;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k == PHASE_ITEMS / 2)
					drain_results();
				send_and_track(random_item(), 1'b0, NO_RGB);
			end
			drain_results();
		end

		if (mismatches == 0)
			$display("rainbow_ring_pixel_generator_tb OK");
		else
			$display("rainbow_ring_pixel_generator_tb NOT OK");
		$finish;
	end

endmodule
